// ===== rtl/haptic_pulse_pattern_generator_defines.svh =====
// ----------------------------------------------------------------------------
// haptic pulse pattern generator assertion macros
// shared concurrent assertion helpers, clocked on clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef HAPTIC_PULSE_PATTERN_GENERATOR_DEFINES_SVH
`define HAPTIC_PULSE_PATTERN_GENERATOR_DEFINES_SVH

// same-cycle implication
`define HPPG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HPPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hppg_pkg.sv =====
// ----------------------------------------------------------------------------
// hppg_pkg
// types, sizes and helpers for the haptic pulse pattern generator
// ----------------------------------------------------------------------------
package hppg_pkg;

	localparam int TIME_BITS  = 16;
	localparam int COUNT_BITS = 8;

	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_SINGLE  = 2'd1,
		OP_PATTERN = 2'd2
	} op_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  pulse_count;
		logic [15:0] on_time_ms;
		logic [15:0] off_time_ms;
	} item_t;

	typedef struct packed {
		logic       motor_on;
		logic       busy_res;
		logic [7:0] pulses_left;
	} result_t;

	localparam logic [32:0] TIME_MAX_W  = (33'd1 << TIME_BITS) - 33'd1;
	localparam logic [16:0] COUNT_MAX_W = (17'd1 << COUNT_BITS) - 17'd1;

	// clamp a 16-bit time to the timer width
	function automatic time_t sat_time(input logic [15:0] v);
		logic [32:0] w;
		w = 33'(v);
		if (w > TIME_MAX_W)
			w = TIME_MAX_W;
		return time_t'(w);
	endfunction

	// clamp a pulse count to the counter width
	function automatic count_t sat_count(input logic [7:0] v);
		logic [16:0] w;
		w = 17'(v);
		if (w > COUNT_MAX_W)
			w = COUNT_MAX_W;
		return count_t'(w);
	endfunction

	// report the counter as 8 bits, clamped
	function automatic logic [7:0] report_count(input count_t v);
		logic [16:0] w;
		w = 17'(v);
		if (w > 17'd255)
			w = 17'd255;
		return w[7:0];
	endfunction

endpackage

// ===== rtl/hppg_core.sv =====
// ----------------------------------------------------------------------------
// hppg_core
// pulse train state and one-item update, result formed from the new state
// ----------------------------------------------------------------------------
`include "haptic_pulse_pattern_generator_defines.svh"

module hppg_core
	import hppg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t result
);

	logic   running_q, pausing_q, drive_q;
	time_t  elapsed_q, limit_q, on_q, off_q;
	count_t rem_q;

	logic   running_d, pausing_d, drive_d;
	time_t  elapsed_d, limit_d, on_d, off_d, el_inc, on_sat;
	count_t rem_d;

	always_comb begin
		running_d = running_q;
		pausing_d = pausing_q;
		drive_d   = drive_q;
		elapsed_d = elapsed_q;
		limit_d   = limit_q;
		on_d      = on_q;
		off_d     = off_q;
		rem_d     = rem_q;
		on_sat    = sat_time(item.on_time_ms);
		el_inc    = (elapsed_q != '1) ? elapsed_q + time_t'(1) : elapsed_q;

		case (item.operation)
			OP_TICK: begin
				if (running_q) begin
					elapsed_d = el_inc;
					if (el_inc >= limit_q) begin
						if (!pausing_q) begin
							drive_d = 1'b0;
							if (rem_q != '0) begin
								pausing_d = 1'b1;
								elapsed_d = '0;
								limit_d   = off_q;
							end else begin
								running_d = 1'b0;
							end
						end else begin
							rem_d     = rem_q - count_t'(1);
							drive_d   = 1'b1;
							running_d = 1'b1;
							pausing_d = 1'b0;
							elapsed_d = '0;
							limit_d   = on_q;
						end
					end
				end
			end
			OP_SINGLE: begin
				rem_d     = '0;
				drive_d   = 1'b1;
				running_d = 1'b1;
				pausing_d = 1'b0;
				elapsed_d = '0;
				limit_d   = on_sat;
			end
			OP_PATTERN: begin
				on_d      = on_sat;
				off_d     = sat_time(item.off_time_ms);
				rem_d     = sat_count((item.pulse_count == 8'd0) ? 8'd0
					: item.pulse_count - 8'd1);
				drive_d   = 1'b1;
				running_d = 1'b1;
				pausing_d = 1'b0;
				elapsed_d = '0;
				limit_d   = on_sat;
			end
			default: begin
			end
		endcase

		result.motor_on    = drive_d;
		result.busy_res    = running_d;
		result.pulses_left = report_count(rem_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pausing_q <= 1'b0;
			drive_q   <= 1'b0;
			elapsed_q <= '0;
			limit_q   <= '0;
			on_q      <= '0;
			off_q     <= '0;
			rem_q     <= '0;
		end else if (en) begin
			running_q <= running_d;
			pausing_q <= pausing_d;
			drive_q   <= drive_d;
			elapsed_q <= elapsed_d;
			limit_q   <= limit_d;
			on_q      <= on_d;
			off_q     <= off_d;
			rem_q     <= rem_d;
		end
	end

	`HPPG_ASSERT_NOW(a_pause_motor_off, pausing_q, running_q && !drive_q, "pause with motor on")
	`HPPG_ASSERT_NOW(a_drive_needs_run, drive_q, running_q, "motor on while idle")
	`HPPG_ASSERT_NOW(a_elapsed_in_range, running_q, elapsed_q <= limit_q, "elapsed past limit")
	`HPPG_ASSERT_NOW(a_left_needs_run, rem_q != '0, running_q, "pulses left while idle")

endmodule

// ===== rtl/haptic_pulse_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// haptic_pulse_pattern_generator
// vibration motor pulse and pulse train timing, one result per command
// ----------------------------------------------------------------------------
// channel  dir  tdata                                 tuser
// s        in   pulse_count, on_time_ms, off_time_ms  operation
// m        out  motor_on, busy_res, pulses_left       -
//
// one command per cycle while no held result stalls the input register
// input register feeds the state update, result lands in an output register
// a held result stalls the input register only while it is also full
// arst_n clears state, motor off, no result pending
// ----------------------------------------------------------------------------
module haptic_pulse_pattern_generator
	import hppg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // pulse_count, on_time_ms, off_time_ms
	input  logic [1:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // motor_on, busy_res, pulses_left, zero pad
);

	logic    valid_s1, out_valid_q, advance;
	item_t   item_s1;
	result_t res_next, res_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation   <= op_t'(s_tuser);
			item_s1.pulse_count <= s_tdata[7:0];
			item_s1.on_time_ms  <= s_tdata[23:8];
			item_s1.off_time_ms <= s_tdata[39:24];
		end
		if (advance)
			res_q <= res_next;
	end

	hppg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (res_next)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q.pulses_left, res_q.busy_res, res_q.motor_on};

endmodule

// ===== verif/haptic_pulse_pattern_generator_checker.sv =====
// ----------------------------------------------------------------------------
// haptic_pulse_pattern_generator_checker
// watches both stream channels, tracks the motor timing on every accepted
// command and compares each result transfer with the oldest prediction
// ----------------------------------------------------------------------------
module haptic_pulse_pattern_generator_checker
	import hppg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // pulse_count, on_time_ms, off_time_ms
	input  logic [1:0]  s_tuser,  // operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // motor_on, busy_res, pulses_left, zero pad
	output int          errors,
	output int          pending,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic   run_st      = 1'b0;
	logic   pause_st    = 1'b0;
	logic   drive_st    = 1'b0;
	time_t  elapsed_st  = '0;
	time_t  limit_st    = '0;
	time_t  pat_on_st   = '0;
	time_t  pat_off_st  = '0;
	count_t left_st     = '0;

	result_t drive_expected[$];
	int      fail_count = 0;
	int      n_pending  = 0;
	int      n_checked  = 0;

	assign errors  = fail_count;
	assign pending = n_pending;
	assign checked = n_checked;

	task automatic report_mismatch(input string what, input int want, input int seen);
		fail_count++;
		$display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, seen);
	endtask

	task automatic start_pulse(input time_t len);
		drive_st   = 1'b1;
		run_st     = 1'b1;
		pause_st   = 1'b0;
		elapsed_st = '0;
		limit_st   = len;
	endtask

	task automatic predict_drive(input logic [1:0] op, input logic [7:0] cnt,
			input time_t on_t, input time_t off_t, output result_t r);
		case (op)
			OP_TICK: begin
				if (run_st) begin
					if (elapsed_st != '1)
						elapsed_st = elapsed_st + time_t'(1);
					if (elapsed_st >= limit_st) begin
						if (!pause_st) begin
							drive_st = 1'b0;
							if (left_st != '0) begin
								pause_st   = 1'b1;
								elapsed_st = '0;
								limit_st   = pat_off_st;
							end else begin
								run_st = 1'b0;
							end
						end else begin
							left_st = left_st - count_t'(1);
							start_pulse(pat_on_st);
						end
					end
				end
			end
			OP_SINGLE: begin
				left_st = '0;
				start_pulse(on_t);
			end
			OP_PATTERN: begin
				pat_on_st  = on_t;
				pat_off_st = off_t;
				left_st    = (cnt == 8'd0) ? count_t'(0) : count_t'(cnt - 8'd1);
				start_pulse(on_t);
			end
			default: begin
			end
		endcase
		r.motor_on    = drive_st;
		r.busy_res    = run_st;
		r.pulses_left = left_st;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t seen;
		if (!arst_n) begin
			run_st     = 1'b0;
			pause_st   = 1'b0;
			drive_st   = 1'b0;
			elapsed_st = '0;
			limit_st   = '0;
			pat_on_st  = '0;
			pat_off_st = '0;
			left_st    = '0;
			drive_expected.delete();
			n_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.motor_on    = m_tdata[0];
				seen.busy_res    = m_tdata[1];
				seen.pulses_left = m_tdata[9:2];
				if (drive_expected.size() == 0) begin
					report_mismatch("result transfer with no command pending", 0, 1);
				end else begin
					want = drive_expected.pop_front();
					n_checked++;
					if (seen.motor_on != want.motor_on)
						report_mismatch("motor_on", want.motor_on, seen.motor_on);
					if (seen.busy_res != want.busy_res)
						report_mismatch("busy_res", want.busy_res, seen.busy_res);
					if (seen.pulses_left != want.pulses_left)
						report_mismatch("pulses_left", want.pulses_left, seen.pulses_left);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_drive(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24], want);
				drive_expected.push_back(want);
			end
			n_pending = drive_expected.size();
		end
	end

endmodule

// ===== verif/haptic_pulse_pattern_generator_tb.sv =====
// ----------------------------------------------------------------------------
// haptic_pulse_pattern_generator_tb
// drives tick, single pulse and pattern commands into the pulse generator,
// directed corner cases first and then random pulse bursts under varying
// back-pressure, and reports the checker's verdict
// ----------------------------------------------------------------------------
module haptic_pulse_pattern_generator_tb;
	import hppg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         N_RANDOM    = 1000;
	localparam int         HOLD_CYCLES = 200;
	localparam int         LIMIT       = 200000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;  // pulse_count, on_time_ms, off_time_ms
	logic [1:0]  s_tuser  = '0;  // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // motor_on, busy_res, pulses_left, zero pad

	int errors;
	int pending;
	int checked;

	int src_idle_pct  = 9;
	int sink_idle_pct = 87;
	logic hold_go     = 1'b0;
	int hold_cnt      = 0;
	int cycle_count   = 0;

	int n_tick    = 0;
	int n_single  = 0;
	int n_pattern = 0;
	int n_unused  = 0;
	int n_random  = 0;

	haptic_pulse_pattern_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	haptic_pulse_pattern_generator_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	initial forever #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("haptic_pulse_pattern_generator: mismatch");
			$finish;
		end
	end

	// receiver: long hold-off once, random stalls otherwise
	always @(posedge clk) begin
		if (hold_go && hold_cnt < HOLD_CYCLES) begin
			hold_cnt++;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic offer_command(input logic [1:0] op, input logic [7:0] cnt,
			input logic [15:0] on_t, input logic [15:0] off_t);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {off_t, on_t, cnt};
		do
			@(posedge clk);
		while (!s_tready);
		case (op)
			OP_TICK:    n_tick++;
			OP_SINGLE:  n_single++;
			OP_PATTERN: n_pattern++;
			default:    n_unused++;
		endcase
	endtask

	task automatic offer_tick();
		offer_command(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic pick_start(output logic [1:0] op, output logic [7:0] cnt,
			output logic [15:0] on_t, output logic [15:0] off_t);
		op   = ($urandom_range(2) == 0) ? OP_SINGLE : OP_PATTERN;
		cnt  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5));
		on_t = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(6));
		off_t = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(6));
	endtask

	// one start followed by a run of ticks, with the odd restart or unused code
	task automatic run_burst();
		logic [1:0]  op;
		logic [7:0]  cnt;
		logic [15:0] on_t;
		logic [15:0] off_t;
		int          n_ticks;
		int          r;
		pick_start(op, cnt, on_t, off_t);
		offer_command(op, cnt, on_t, off_t);
		n_random++;
		n_ticks = $urandom_range(1, 40);
		repeat (n_ticks) begin
			r = $urandom_range(99);
			if (r < 3) begin
				offer_command(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
			end else if (r < 5) begin
				pick_start(op, cnt, on_t, off_t);
				offer_command(op, cnt, on_t, off_t);
				n_random++;
			end else begin
				offer_tick();
				n_random++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick and unused code
		offer_command(OP_TICK, 8'hff, 16'hffff, 16'hffff);
		offer_command(OP_UNUSED, 8'h00, 16'h0000, 16'h0000);
		// zero-length single pulse
		offer_command(OP_SINGLE, 8'hff, 16'd0, 16'hffff);
		offer_tick();
		offer_command(OP_SINGLE, 8'd0, 16'd2, 16'hffff);
		offer_tick();
		offer_tick();
		// pattern count of zero counts as one
		offer_command(OP_PATTERN, 8'd0, 16'd1, 16'd0);
		offer_tick();
		// zero on and off times
		offer_command(OP_PATTERN, 8'd3, 16'd0, 16'd0);
		repeat (5) offer_tick();
		// longest pattern, then abandoned
		offer_command(OP_PATTERN, 8'hff, 16'hffff, 16'hffff);
		offer_tick();
		offer_command(OP_UNUSED, 8'h5a, 16'h1234, 16'hfedc);
		offer_command(OP_SINGLE, 8'h7f, 16'd1, 16'd7);
		offer_tick();
		offer_command(OP_PATTERN, 8'd2, 16'd1, 16'd2);
		repeat (3) offer_tick();
		offer_command(OP_PATTERN, 8'd1, 16'd3, 16'd9);

		while (n_random < N_RANDOM) begin
			if (n_random >= 2 * N_RANDOM / 3) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
				hold_go       = 1'b1;
			end else if (n_random >= N_RANDOM / 3) begin
				src_idle_pct  = 87;
				sink_idle_pct = 9;
			end
			run_burst();
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("commands sent: %0d ticks, %0d single starts, %0d pattern starts, %0d unused",
			n_tick, n_single, n_pattern, n_unused);
		$display("results compared: %0d, with one %0d-cycle output hold-off", checked,
			HOLD_CYCLES);
		if (errors == 0)
			$display("haptic_pulse_pattern_generator: match");
		else
			$display("haptic_pulse_pattern_generator: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hppg_pkg.sv
rtl/hppg_core.sv
rtl/haptic_pulse_pattern_generator.sv
verif/haptic_pulse_pattern_generator_checker.sv
verif/haptic_pulse_pattern_generator_tb.sv
